// ===== src/hrp_pkg.sv =====
`default_nettype none

package hrp_pkg;

  // Default depth of one record data buffer bank
  localparam int MaxDataBytesDef = 16;

  // Record type codes
  localparam logic [7:0] REC_DATA      = 8'h00;
  localparam logic [7:0] REC_EOF       = 8'h01;
  localparam logic [7:0] REC_EXT_LIN   = 8'h04;
  localparam logic [7:0] REC_START_LIN = 8'h05;

  // Finished record, handed from the parser to the emitter
  typedef struct packed {
    logic [7:0]  kind;
    logic        ok;
    logic        tl;
    logic [7:0]  len;
    logic [31:0] base;
    logic [31:0] start;
    logic        bank;
  } desc_t;

  // Write port into the data buffer
  typedef struct packed {
    logic       en;
    logic       bank;
    logic [7:0] idx;
    logic [7:0] data;
  } mem_wr_t;

  // One result item
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] byte_address;
    logic        has_data;
    logic [7:0]  record_type;
    logic        checksum_ok;
    logic        end_of_file;
    logic [31:0] start_address;
    logic        too_long;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// ===== src/hrp_front.sv =====
`default_nettype none

module hrp_front #(
  parameter int MAX_DATA_BYTES = hrp_pkg::MaxDataBytesDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [7:0]      in_byte_i,
  input  wire logic            in_done_i,
  output logic                 in_ready_o,
  input  wire logic            q_full_i,
  output logic                 push_o,
  output hrp_pkg::desc_t       desc_o,
  output hrp_pkg::mem_wr_t     wr_o
);

  localparam logic [7:0] MaxB = 8'(MAX_DATA_BYTES);

  // Position within the record
  localparam logic [2:0] POS_COUNT   = 3'd0;
  localparam logic [2:0] POS_ADDR_HI = 3'd1;
  localparam logic [2:0] POS_ADDR_LO = 3'd2;
  localparam logic [2:0] POS_TYPE    = 3'd3;
  localparam logic [2:0] POS_BODY    = 3'd4;

  logic [2:0]      pos_q, pos_d;
  logic [7:0]      len_q, len_d;
  logic [15:0]     low_q, low_d;
  logic [7:0]      kind_q, kind_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      cnt_q, cnt_d;
  logic [3:0][7:0] pl_q, pl_d;
  logic [15:0]     upper_q, upper_d;
  logic [31:0]     entry_q, entry_d;
  logic            bank_q, bank_d;
  logic            take;
  logic [7:0]      sum_next;
  logic            tl;

  // Stall while both buffer banks hold records not yet drained
  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && in_ready_o && in_done_i;
  assign sum_next   = sum_q + in_byte_i;
  assign tl         = len_q > MaxB;

  // Record parser
  always_comb begin
    pos_d   = pos_q;
    len_d   = len_q;
    low_d   = low_q;
    kind_d  = kind_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    pl_d    = pl_q;
    upper_d = upper_q;
    entry_d = entry_q;
    bank_d  = bank_q;
    push_o  = 1'b0;
    wr_o    = '0;
    desc_o  = '0;
    if (take) begin
      sum_d = sum_next;
      unique case (pos_q)
        POS_COUNT: begin
          sum_d = in_byte_i;
          len_d = in_byte_i;
          cnt_d = '0;
          pl_d  = '0;
          pos_d = POS_ADDR_HI;
        end
        POS_ADDR_HI: begin
          low_d = {in_byte_i, 8'h00};
          pos_d = POS_ADDR_LO;
        end
        POS_ADDR_LO: begin
          low_d[7:0] = in_byte_i;
          pos_d      = POS_TYPE;
        end
        POS_TYPE: begin
          kind_d = in_byte_i;
          pos_d  = POS_BODY;
        end
        POS_BODY: begin
          if (cnt_q < len_q) begin
            // data byte
            wr_o.en   = cnt_q < MaxB;
            wr_o.bank = bank_q;
            wr_o.idx  = cnt_q;
            wr_o.data = in_byte_i;
            if (cnt_q < 8'd4) begin
              pl_d[cnt_q[1:0]] = in_byte_i;
            end
            cnt_d = cnt_q + 8'd1;
          end else begin
            // checksum byte: record done
            pos_d = POS_COUNT;
            if (!tl && kind_q == hrp_pkg::REC_EXT_LIN) begin
              upper_d = {pl_q[0], pl_q[1]};
            end
            if (!tl && kind_q == hrp_pkg::REC_START_LIN) begin
              entry_d = {pl_q[0], pl_q[1], pl_q[2], pl_q[3]};
            end
            push_o       = 1'b1;
            desc_o.kind  = kind_q;
            desc_o.ok    = sum_next == 8'h00;
            desc_o.tl    = tl;
            desc_o.len   = len_q;
            desc_o.base  = {upper_q, low_q};
            desc_o.start = entry_d;
            desc_o.bank  = bank_q;
            bank_d       = !bank_q;
          end
        end
        default: pos_d = POS_COUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= POS_COUNT;
      len_q   <= '0;
      low_q   <= '0;
      kind_q  <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      pl_q    <= '0;
      upper_q <= '0;
      entry_q <= '0;
      bank_q  <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      len_q   <= len_d;
      low_q   <= low_d;
      kind_q  <= kind_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      pl_q    <= pl_d;
      upper_q <= upper_d;
      entry_q <= entry_d;
      bank_q  <= bank_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/hrp_queue.sv =====
`default_nettype none

module hrp_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire hrp_pkg::desc_t desc_i,
  output logic                full_o,
  output logic                valid_o,
  output hrp_pkg::desc_t      head_o,
  input  wire logic           pop_i
);

  // Two entries, one for each buffer bank
  hrp_pkg::desc_t [1:0] ent_q;
  logic                 wp_q, rp_q;
  logic [1:0]           cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign head_o  = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

`default_nettype wire

// ===== src/hrp_back.sv =====
`default_nettype none

module hrp_back #(
  parameter int MAX_DATA_BYTES = hrp_pkg::MaxDataBytesDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire hrp_pkg::mem_wr_t wr_i,
  input  wire logic             head_valid_i,
  input  wire hrp_pkg::desc_t   head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  output hrp_pkg::res_t         out_o,
  input  wire logic             out_ready_i
);

  localparam int IW    = $clog2(MAX_DATA_BYTES);
  localparam int Depth = 2 << IW;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic [7:0]        mem [Depth];
  logic [7:0]        rdata_q;
  logic              st_q, st_d;
  logic [7:0]        idx_q, idx_d;
  logic              ov_q, ov_d;
  hrp_pkg::res_t     res_q, res_d;
  logic              out_free;
  logic              is_data;
  logic              is_last;
  logic [IW:0]       waddr, raddr;

  assign waddr = {wr_i.bank, wr_i.idx[IW-1:0]};
  assign raddr = {head_i.bank, idx_d[IW-1:0]};

  // Two-bank record buffer, registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[waddr] <= wr_i.data;
    end
    rdata_q <= mem[raddr];
  end

  assign out_free = !ov_q || out_ready_i;
  assign is_data  = head_i.kind == hrp_pkg::REC_DATA && !head_i.tl && head_i.len != 8'd0;
  assign is_last  = (idx_q + 8'd1) == head_i.len;

  // Emitter: one status item, or one item per data byte
  always_comb begin
    st_d  = st_q;
    idx_d = idx_q;
    ov_d  = ov_q && !out_ready_i;
    res_d = res_q;
    pop_o = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          if (is_data) begin
            idx_d = '0;
            st_d  = ST_EMIT;
          end else if (out_free) begin
            ov_d                = 1'b1;
            pop_o               = 1'b1;
            res_d.data_byte     = '0;
            res_d.byte_address  = '0;
            res_d.has_data      = 1'b0;
            res_d.record_type   = head_i.kind;
            res_d.checksum_ok   = head_i.ok;
            res_d.end_of_file   = head_i.kind == hrp_pkg::REC_EOF;
            res_d.start_address = head_i.start;
            res_d.too_long      = head_i.tl;
            res_d.last          = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_d                = 1'b1;
          res_d.data_byte     = rdata_q;
          res_d.byte_address  = head_i.base + {24'd0, idx_q};
          res_d.has_data      = 1'b1;
          res_d.record_type   = head_i.kind;
          res_d.checksum_ok   = head_i.ok;
          res_d.end_of_file   = head_i.kind == hrp_pkg::REC_EOF;
          res_d.start_address = head_i.start;
          res_d.too_long      = 1'b0;
          res_d.last          = is_last;
          if (is_last) begin
            pop_o = 1'b1;
            st_d  = ST_IDLE;
          end else begin
            idx_d = idx_q + 8'd1;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
      ov_q  <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_o       = res_q;

endmodule

`default_nettype wire

// ===== src/hex_record_parser_unit.sv =====
// Intel HEX record parser, fed one binary record byte per item.
// Input stream: s_axis_tdata carries the byte, s_axis_tuser says the transfer
// is complete; items with tuser low are taken and dropped.
// Output stream: one item per data byte of a type 00 record that is neither
// empty nor over-long (tuser high), or one status item for any other record;
// tlast marks the final item. The front parser takes one byte per cycle
// unless the queue is full. At the checksum byte it hands the record to the
// emitter through a two-entry queue; each entry owns one bank of the data
// buffer, so the next record fills one bank while the emitter drains the
// other. s_axis_tready drops only while both banks hold records not yet
// drained. A record's descriptor is registered in the queue; a status item
// then goes into the output register, data items through the registered
// buffer read into it, one per cycle while the receiver takes them. A stalled
// receiver holds the output register and the emitter; the parser keeps going
// until the queue is full. Reset clears parser state, the queue and the output
// valid; no clearing pass is needed.
`default_nettype none

module hex_record_parser_unit #(
  parameter int MAX_DATA_BYTES = hrp_pkg::MaxDataBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] byte_value
  input  wire logic        s_axis_tuser,  // [0] transfer_complete
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] data_byte, [39:8] byte_address, [47:40] record_type,
  // [48] checksum_ok, [49] end_of_file, [81:50] start_address,
  // [82] too_long, [87:83] zero
  output logic [87:0]      m_axis_tdata,
  output logic             m_axis_tuser,  // [0] has_data
  output logic             m_axis_tlast
);

  logic             q_full, q_valid, push, pop;
  hrp_pkg::desc_t   desc, head;
  hrp_pkg::mem_wr_t wr;
  hrp_pkg::res_t    res;

  hrp_front #(.MAX_DATA_BYTES(MAX_DATA_BYTES)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_done_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .q_full_i   (q_full),
    .push_o     (push),
    .desc_o     (desc),
    .wr_o       (wr)
  );

  hrp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head),
    .pop_i   (pop)
  );

  hrp_back #(.MAX_DATA_BYTES(MAX_DATA_BYTES)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .head_valid_i (q_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_o        (res),
    .out_ready_i  (m_axis_tready)
  );

  // Output packing
  assign m_axis_tdata = {5'd0, res.too_long, res.start_address, res.end_of_file,
                         res.checksum_ok, res.record_type, res.byte_address,
                         res.data_byte};
  assign m_axis_tuser = res.has_data;
  assign m_axis_tlast = res.last;

  // A status item is always the last of its record
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("status item without tlast");

  // A data item never reports an oversized record
  a_data_not_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[82])
    else $error("data item flagged too_long");

  // Data items of one record follow back to back at consecutive addresses
  a_data_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tuser &&
      (m_axis_tdata[39:8] == $past(m_axis_tdata[39:8]) + 32'd1))
    else $error("data run broken");

  // The queue never holds more records than there are buffer banks
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push)
    else $error("record pushed into full queue");

endmodule

`default_nettype wire

// ===== bench/hrp_result_checker.sv =====
`default_nettype none

// Watches both streams of the HEX record parser, predicts the result items of
// every accepted record byte and compares them in order with what comes out.
module hrp_result_checker #(
  parameter int MAX_DATA_BYTES = hrp_pkg::MaxDataBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  wire logic        s_axis_tuser,   // [0] transfer_complete
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] data_byte, [39:8] byte_address, [47:40] record_type,
  // [48] checksum_ok, [49] end_of_file, [81:50] start_address,
  // [82] too_long, [87:83] zero
  input  wire logic [87:0] m_axis_tdata,
  input  wire logic        m_axis_tuser,   // [0] has_data
  input  wire logic        m_axis_tlast,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Where the parser stands inside a record
  typedef enum logic [2:0] {
    POS_COUNT,
    POS_ADDR_HI,
    POS_ADDR_LO,
    POS_KIND,
    POS_BODY
  } rec_pos_e;

  // Shadow copy of the parser state
  rec_pos_e    rec_pos;
  logic [7:0]  rec_len;
  logic [15:0] low_addr;
  logic [7:0]  rec_kind;
  logic [7:0]  sum_acc;
  logic [7:0]  body_count;
  logic [7:0]  payload_buf [MAX_DATA_BYTES];
  logic [15:0] upper_addr;
  logic [31:0] entry_addr;

  hrp_pkg::res_t expected_results [$];
  int            mismatches;

  // Data byte i of the record; missing bytes read as zero
  function automatic logic [7:0] payload_at(input int i);
    if (i < int'(body_count) && i < MAX_DATA_BYTES) begin
      return payload_buf[i];
    end
    return 8'h00;
  endfunction

  task automatic queue_result(input logic [7:0] data, input logic [31:0] addr,
                              input logic has, input logic ok, input logic tl,
                              input logic lst);
    hrp_pkg::res_t r;
    r.data_byte     = data;
    r.byte_address  = addr;
    r.has_data      = has;
    r.record_type   = rec_kind;
    r.checksum_ok   = ok;
    r.end_of_file   = (rec_kind == hrp_pkg::REC_EOF);
    r.start_address = entry_addr;
    r.too_long      = tl;
    r.last          = lst;
    expected_results.push_back(r);
  endtask

  // Advance the shadow parser by one record byte
  task automatic parse_record_byte(input logic [7:0] b);
    logic        ok;
    logic        tl;
    logic [31:0] base;
    int          i;
    sum_acc = sum_acc + b;
    case (rec_pos)
      POS_COUNT: begin
        sum_acc    = b;
        rec_len    = b;
        body_count = 8'd0;
        rec_pos    = POS_ADDR_HI;
      end
      POS_ADDR_HI: begin
        low_addr = {b, 8'h00};
        rec_pos  = POS_ADDR_LO;
      end
      POS_ADDR_LO: begin
        low_addr[7:0] = b;
        rec_pos       = POS_KIND;
      end
      POS_KIND: begin
        rec_kind = b;
        rec_pos  = POS_BODY;
      end
      default: begin
        if (body_count < rec_len) begin
          if (body_count < MAX_DATA_BYTES) begin
            payload_buf[body_count] = b;
          end
          body_count = body_count + 8'd1;
        end else begin
          // checksum byte closes the record
          rec_pos = POS_COUNT;
          ok      = (sum_acc == 8'h00);
          tl      = (rec_len > MAX_DATA_BYTES);
          if (!tl && rec_kind == hrp_pkg::REC_DATA && rec_len != 8'd0) begin
            base = {upper_addr, low_addr};
            for (i = 0; i < int'(rec_len); i++) begin
              queue_result(payload_at(i), base + 32'(i), 1'b1, ok, 1'b0,
                           i + 1 == int'(rec_len));
            end
          end else begin
            if (!tl && rec_kind == hrp_pkg::REC_EXT_LIN) begin
              upper_addr = {payload_at(0), payload_at(1)};
            end else if (!tl && rec_kind == hrp_pkg::REC_START_LIN) begin
              entry_addr = {payload_at(0), payload_at(1), payload_at(2), payload_at(3)};
            end
            queue_result(8'h00, 32'h0, 1'b0, ok, tl, 1'b1);
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
      mismatches++;
    end
  endtask

  // Predict on accepted input items, compare on accepted result items
  always @(posedge clk_i or negedge rst_ni) begin
    hrp_pkg::res_t want;
    if (!rst_ni) begin
      rec_pos    = POS_COUNT;
      rec_len    = 8'd0;
      low_addr   = 16'd0;
      rec_kind   = 8'd0;
      sum_acc    = 8'd0;
      body_count = 8'd0;
      upper_addr = 16'd0;
      entry_addr = 32'd0;
      for (int i = 0; i < MAX_DATA_BYTES; i++) payload_buf[i] = 8'h00;
      expected_results.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready && s_axis_tuser) begin
        parse_record_byte(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result item with nothing expected, expected none, got %h/%b/%b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("data_byte", 32'(want.data_byte), 32'(m_axis_tdata[7:0]));
          check_field("byte_address", want.byte_address, m_axis_tdata[39:8]);
          check_field("has_data", 32'(want.has_data), 32'(m_axis_tuser));
          check_field("record_type", 32'(want.record_type), 32'(m_axis_tdata[47:40]));
          check_field("checksum_ok", 32'(want.checksum_ok), 32'(m_axis_tdata[48]));
          check_field("end_of_file", 32'(want.end_of_file), 32'(m_axis_tdata[49]));
          check_field("start_address", want.start_address, m_axis_tdata[81:50]);
          check_field("too_long", 32'(want.too_long), 32'(m_axis_tdata[82]));
          check_field("tdata padding", 32'h0, 32'(m_axis_tdata[87:83]));
          check_field("last", 32'(want.last), 32'(m_axis_tlast));
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_results.size();
    end
  end

endmodule

`default_nettype wire

// ===== bench/hex_record_parser_unit_test.sv =====
`default_nettype none

module hex_record_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Record types the package does not name
  localparam logic [7:0] REC_EXT_SEG   = 8'h02;
  localparam logic [7:0] REC_START_SEG = 8'h03;
  localparam logic [7:0] REC_ODD_KIND  = 8'hA7;

  localparam int RAND_BYTES  = 64;    // record bytes in the random part
  localparam int QUIET_BYTES = 20;    // tail of the random part with no idling
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int IDLE_LIMIT  = 4000;  // cycles with no accepted item

  logic        clk;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tready = 1'b0;
  wire logic   s_tready;
  wire logic   m_tvalid;
  wire logic [87:0] m_tdata;
  wire logic   m_tuser;
  wire logic   m_tlast;

  int fail_count;
  int pending;
  int byte_total = 0;
  int idle_cycles = 0;
  bit tx_gaps = 1'b0;
  bit rx_gaps = 1'b0;
  bit rx_hold_req = 1'b0;

  hex_record_parser_unit DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  hrp_result_checker CHECK (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one item and wait for it to be taken; may idle afterwards
  task automatic send_item(input logic [7:0] b, input logic complete);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= complete;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (complete) byte_total++;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Record byte, sometimes preceded by a byte of an unfinished transfer
  task automatic put_byte(input logic [7:0] b);
    if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0);
    send_item(b, 1'b1);
  endtask

  // One record; the first four data bytes come from lead, the rest are random
  task automatic emit_record(input logic [7:0] kind, input int cnt,
                             input logic [15:0] addr, input logic [31:0] lead,
                             input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    int         i;
    sum = cnt[7:0] + addr[15:8] + addr[7:0] + kind;
    put_byte(cnt[7:0]);
    put_byte(addr[15:8]);
    put_byte(addr[7:0]);
    put_byte(kind);
    for (i = 0; i < cnt; i++) begin
      b   = (i < 4) ? lead[31 - 8 * i -: 8] : 8'($urandom);
      sum = sum + b;
      put_byte(b);
    end
    b = 8'h00 - sum;
    if (bad_sum) b = b ^ 8'($urandom_range(1, 255));
    put_byte(b);
  endtask

  // Stop offering and wait until every expected result item has come
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int         sel;
    int         cnt;
    int         rec_no;
    logic [7:0] kind;
    logic [15:0] addr;
    bit         saved_gaps;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed records
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    emit_record(hrp_pkg::REC_DATA, 0, 16'h0000, 32'h0, 1'b0);
    emit_record(hrp_pkg::REC_DATA, 4, 16'h1234, 32'hFF00_FF00, 1'b0);
    emit_record(hrp_pkg::REC_EXT_LIN, 2, 16'h0000, 32'hFFFF_0000, 1'b0);
    // address wraps past the top of the 32-bit space
    emit_record(hrp_pkg::REC_DATA, 2, 16'hFFFF, 32'h00FF_00FF, 1'b0);
    // short address records: missing bytes read as zero
    emit_record(hrp_pkg::REC_EXT_LIN, 1, 16'h0000, 32'hAB00_0000, 1'b0);
    emit_record(hrp_pkg::REC_START_LIN, 2, 16'h0000, 32'h1234_5678, 1'b0);
    emit_record(REC_ODD_KIND, 1, 16'h5A5A, 32'hA5A5_A5A5, 1'b0);
    // bad checksum still acts on the record
    emit_record(hrp_pkg::REC_EXT_LIN, 2, 16'h0000, 32'h8001_0000, 1'b1);
    // over-long record changes no address state
    emit_record(hrp_pkg::REC_EXT_LIN, 17, 16'h0000, 32'h2222_2222, 1'b0);
    emit_record(hrp_pkg::REC_EOF, 0, 16'h0000, 32'h0, 1'b0);
    wait_drained();

    // Random records, mostly well formed
    tx_gaps    = 1'b1;
    rx_gaps    = 1'b1;
    byte_total = 0;
    rec_no     = 0;
    while (byte_total < RAND_BYTES) begin
      if (byte_total >= RAND_BYTES - QUIET_BYTES) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      if (rec_no == 1) begin
        // receiver holds off while records keep coming back to back
        saved_gaps  = tx_gaps;
        tx_gaps     = 1'b0;
        rx_hold_req = 1'b1;
        repeat (3) emit_record(hrp_pkg::REC_DATA, 6, 16'($urandom), $urandom, 1'b0);
        tx_gaps = saved_gaps;
      end else if (rec_no == 3) begin
        wait_drained();
      end
      sel  = $urandom_range(0, 19);
      addr = ($urandom_range(0, 7) == 0) ? 16'hFFF8 : 16'($urandom);
      if (sel < 10) begin
        kind = hrp_pkg::REC_DATA;
        cnt  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 8);
      end else if (sel < 12) begin
        kind = hrp_pkg::REC_EXT_LIN;
        cnt  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 2;
      end else if (sel < 14) begin
        kind = hrp_pkg::REC_START_LIN;
        cnt  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 4;
      end else if (sel == 14) begin
        kind = hrp_pkg::REC_EOF;
        cnt  = 0;
      end else if (sel == 15) begin
        kind = REC_EXT_SEG;
        cnt  = 2;
      end else if (sel == 16) begin
        kind = REC_START_SEG;
        cnt  = 4;
      end else if (sel == 17) begin
        kind = 8'($urandom_range(6, 255));
        cnt  = $urandom_range(0, 4);
      end else if (sel == 18) begin
        kind = 8'($urandom_range(0, 5));
        cnt  = $urandom_range(17, 24);
      end else begin
        kind = 8'($urandom);
        cnt  = $urandom_range(0, 6);
      end
      emit_record(kind, cnt, addr, $urandom, $urandom_range(0, 7) == 0);
      rec_no++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/hrp_pkg.sv
src/hrp_front.sv
src/hrp_queue.sv
src/hrp_back.sv
src/hex_record_parser_unit.sv
bench/hrp_result_checker.sv
bench/hex_record_parser_unit_test.sv
